[sv/indexed_list_store_top_macros.svh]
// ----------------------------------------------------------------------------
// indexed_list_store_top_macros.svh
// Assertion helpers used by the list store RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_TOP_MACROS_SVH
`define INDEXED_LIST_STORE_TOP_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ILS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("list store check failed");

// Next-cycle implication, checked while out of reset.
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("list store check failed");

`endif

[sv/ils_pkg.sv]
// ----------------------------------------------------------------------------
// ils_pkg
// Request and status codes of the indexed list store.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

	typedef logic [2:0] req_code_t;
	typedef logic [1:0] status_t;

	localparam req_code_t REQ_READ        = 3'd0;
	localparam req_code_t REQ_INSERT_HEAD = 3'd1;
	localparam req_code_t REQ_INSERT_TAIL = 3'd2;
	localparam req_code_t REQ_INSERT_AT   = 3'd3;
	localparam req_code_t REQ_DELETE      = 3'd4;

	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned COUNT_W = 7;

endpackage

`default_nettype wire

[sv/indexed_list_store_top.sv]
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Ordered store of signed 32-bit values kept in one synchronous memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result shows
// on read_value, status and entry_count for exactly one cycle with done high,
// and the receiver cannot stall it. Rejected requests (out of range, full,
// unknown) and a delete of the last entry give their result in the cycle after
// acceptance and allow a new transaction every cycle. A good read passes through
// S_RD_WAIT, as the memory output is registered. An insert that moves no entries
// goes straight to S_PUT, an insert that moves entries passes through S_SHIFT,
// S_DRAIN and S_PUT, and a delete that moves entries through S_SHIFT and S_DRAIN:
// the entries move one per cycle through the memory's single read and write ports.
`default_nettype none

module indexed_list_store_top #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire ils_pkg::req_code_t                  req_type,
	input  wire logic [ils_pkg::POS_W-1:0]           position,
	input  wire logic signed [ils_pkg::DATA_W-1:0]   item_value,
	output logic                                     done,
	output logic signed [ils_pkg::DATA_W-1:0]        read_value,
	output ils_pkg::status_t                         status,
	output logic [ils_pkg::COUNT_W-1:0]              entry_count
);

	import ils_pkg::*;

	`include "indexed_list_store_top_macros.svh"

	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_WAIT,
		S_SHIFT,
		S_DRAIN,
		S_PUT
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              count_q;
	logic [AW-1:0]              src_q;
	logic [AW-1:0]              end_q;
	logic [AW-1:0]              pos_q;
	logic [DATA_W-1:0]          value_q;
	logic                       ins_q;
	logic                       done_q;
	logic signed [DATA_W-1:0]   read_value_q;
	status_t                    status_q;
	logic                       wr_pend_s1;
	logic [AW-1:0]              wr_addr_s1;

	logic [DATA_W-1:0]          mem [CAPACITY];
	logic [DATA_W-1:0]          rdata_q;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [DATA_W-1:0]          mem_wdata;

	logic                       accept;
	logic [CMPW-1:0]            pos_ext;
	logic [CMPW-1:0]            cnt_ext;
	logic [CMPW-1:0]            ins_tgt;
	logic                       is_full;
	logic                       shift_last;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign pos_ext  = CMPW'(position);
	assign cnt_ext  = CMPW'(count_q);
	assign is_full  = (count_q == CW'(CAPACITY));

	always_comb begin
		unique case (req_type)
			REQ_INSERT_HEAD: ins_tgt = '0;
			REQ_INSERT_TAIL: ins_tgt = cnt_ext;
			default:         ins_tgt = pos_ext;
		endcase
	end

	assign shift_last = ins_q ? (src_q == pos_q) : (src_q == end_q);

	// Shifts read two entries ahead of the pending write, so a read never
	// meets an entry that is still waiting to be written back.
	assign mem_re    = (accept && (req_type == REQ_READ) && (pos_ext < cnt_ext))
			|| (state_q == S_SHIFT);
	assign mem_raddr = (state_q == S_SHIFT) ? src_q : AW'(position);
	assign mem_we    = wr_pend_s1 || (state_q == S_PUT);
	assign mem_waddr = (state_q == S_PUT) ? pos_q : wr_addr_s1;
	assign mem_wdata = (state_q == S_PUT) ? value_q : rdata_q;

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			src_q        <= '0;
			end_q        <= '0;
			pos_q        <= '0;
			value_q      <= '0;
			ins_q        <= 1'b0;
			done_q       <= 1'b0;
			read_value_q <= '0;
			status_q     <= ST_DONE;
			wr_pend_s1   <= 1'b0;
			wr_addr_s1   <= '0;
		end else begin
			done_q     <= 1'b0;
			wr_pend_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req_type)
							REQ_READ: begin
								if (pos_ext < cnt_ext) begin
									state_q <= S_RD_WAIT;
								end else begin
									done_q       <= 1'b1;
									read_value_q <= '1;
									status_q     <= ST_RANGE;
								end
							end
							REQ_INSERT_HEAD, REQ_INSERT_TAIL, REQ_INSERT_AT: begin
								if (ins_tgt > cnt_ext) begin
									done_q       <= 1'b1;
									read_value_q <= '0;
									status_q     <= ST_RANGE;
								end else if (is_full) begin
									done_q       <= 1'b1;
									read_value_q <= '0;
									status_q     <= ST_FULL;
								end else begin
									pos_q   <= AW'(ins_tgt);
									value_q <= item_value;
									ins_q   <= 1'b1;
									if (ins_tgt == cnt_ext) begin
										state_q <= S_PUT;
									end else begin
										src_q   <= AW'(count_q - CW'(1));
										state_q <= S_SHIFT;
									end
								end
							end
							REQ_DELETE: begin
								if (pos_ext >= cnt_ext) begin
									done_q       <= 1'b1;
									read_value_q <= '0;
									status_q     <= ST_RANGE;
								end else if (pos_ext + CMPW'(1) == cnt_ext) begin
									count_q      <= count_q - CW'(1);
									done_q       <= 1'b1;
									read_value_q <= '0;
									status_q     <= ST_DONE;
								end else begin
									src_q   <= AW'(position) + AW'(1);
									end_q   <= AW'(count_q - CW'(1));
									ins_q   <= 1'b0;
									state_q <= S_SHIFT;
								end
							end
							default: begin
								done_q       <= 1'b1;
								read_value_q <= '0;
								status_q     <= ST_RANGE;
							end
						endcase
					end
				end
				S_RD_WAIT: begin
					done_q       <= 1'b1;
					read_value_q <= rdata_q;
					status_q     <= ST_DONE;
					state_q      <= S_IDLE;
				end
				S_SHIFT: begin
					wr_pend_s1 <= 1'b1;
					wr_addr_s1 <= ins_q ? (src_q + AW'(1)) : (src_q - AW'(1));
					if (shift_last) begin
						state_q <= S_DRAIN;
					end else begin
						src_q <= ins_q ? (src_q - AW'(1)) : (src_q + AW'(1));
					end
				end
				S_DRAIN: begin
					if (ins_q) begin
						state_q <= S_PUT;
					end else begin
						count_q      <= count_q - CW'(1);
						done_q       <= 1'b1;
						read_value_q <= '0;
						status_q     <= ST_DONE;
						state_q      <= S_IDLE;
					end
				end
				S_PUT: begin
					count_q      <= count_q + CW'(1);
					done_q       <= 1'b1;
					read_value_q <= '0;
					status_q     <= ST_DONE;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_count = COUNT_W'(count_q);

	`ILS_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`ILS_ASSERT_IMPLY(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)
	`ILS_ASSERT_IMPLY(a_wr_in_shift, clk, arst_n, wr_pend_s1, state_q == S_SHIFT || state_q == S_DRAIN)
	`ILS_ASSERT_IMPLY(a_count_with_done, clk, arst_n, count_q != $past(count_q), done_q)
	`ILS_ASSERT_NEXT(a_put_finishes, clk, arst_n, state_q == S_PUT, done_q && state_q == S_IDLE)

endmodule

`default_nettype wire

[test/tb_indexed_list_store_top.sv]
// ----------------------------------------------------------------------------
// tb_indexed_list_store_top
// Self-checking bench for the indexed list store.
// ----------------------------------------------------------------------------
// Requests go in through the start/busy handshake in bursts with random gaps.
// A scoreboard keeps its own copy of the list and predicts read_value, status
// and entry_count for every accepted transaction. Each done pulse is checked
// against the oldest prediction. Phases drive the list from empty to full and
// back, with reads, every kind of insert, deletes and unused request codes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_indexed_list_store_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ils_pkg::*;

	localparam int unsigned CAPACITY    = 64;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned PRINT_CAP   = 40;

	localparam req_code_t REQ_UNUSED_A = 3'd5;
	localparam req_code_t REQ_UNUSED_B = 3'd6;
	localparam req_code_t REQ_UNUSED_C = 3'd7;

	localparam logic signed [DATA_W-1:0] OUT_OF_RANGE_VALUE = -32'sd1;
	localparam logic signed [DATA_W-1:0] VALUE_MAX          = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] VALUE_MIN          = 32'sh8000_0000;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		status_t                  status;
		logic [COUNT_W-1:0]       count;
	} list_result_t;

	class list_scoreboard;
		logic signed [DATA_W-1:0] cells [CAPACITY];
		int unsigned count;
		list_result_t pending_results[$];
		int unsigned error_count;
		int unsigned n_checked;
		int unsigned n_read, n_insert, n_delete, n_unknown;
		int unsigned n_full, n_range, peak_count;

		function new();
			count = 0;
			error_count = 0;
			n_checked = 0;
			n_read = 0;
			n_insert = 0;
			n_delete = 0;
			n_unknown = 0;
			n_full = 0;
			n_range = 0;
			peak_count = 0;
			foreach (cells[i]) cells[i] = '0;
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		task report(input string msg);
			error_count++;
			if (error_count <= PRINT_CAP)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		function status_t insert_cell(input int unsigned p, input logic signed [DATA_W-1:0] v);
			// The range check comes before the full check.
			if (p > count)
				return ST_RANGE;
			if (count >= CAPACITY)
				return ST_FULL;
			for (int unsigned i = count; i > p; i--)
				cells[i] = cells[i - 1];
			cells[p] = v;
			count++;
			return ST_DONE;
		endfunction

		function status_t delete_cell(input int unsigned p);
			if (p >= count)
				return ST_RANGE;
			for (int unsigned i = p; i + 1 < count; i++)
				cells[i] = cells[i + 1];
			count--;
			return ST_DONE;
		endfunction

		function void note_request(input req_code_t kind, input logic [POS_W-1:0] pos,
				input logic signed [DATA_W-1:0] v);
			list_result_t e;
			int unsigned p;
			p = pos;
			e.value = '0;
			e.status = ST_DONE;
			case (kind)
				REQ_READ: begin
					n_read++;
					if (p < count) begin
						e.value = cells[p];
					end else begin
						e.value = OUT_OF_RANGE_VALUE;
						e.status = ST_RANGE;
					end
				end
				REQ_INSERT_HEAD: begin
					n_insert++;
					e.status = insert_cell(0, v);
				end
				REQ_INSERT_TAIL: begin
					n_insert++;
					e.status = insert_cell(count, v);
				end
				REQ_INSERT_AT: begin
					n_insert++;
					e.status = insert_cell(p, v);
				end
				REQ_DELETE: begin
					n_delete++;
					e.status = delete_cell(p);
				end
				default: begin
					n_unknown++;
					e.status = ST_RANGE;
				end
			endcase
			if (e.status == ST_FULL)
				n_full++;
			if (e.status == ST_RANGE)
				n_range++;
			if (count > peak_count)
				peak_count = count;
			e.count = COUNT_W'(count);
			pending_results.push_back(e);
		endfunction

		task check_result(input logic signed [DATA_W-1:0] rv, input status_t st,
				input logic [COUNT_W-1:0] cnt);
			list_result_t e;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing pending: value=%0d status=%0d count=%0d",
					rv, st, cnt));
				return;
			end
			e = pending_results.pop_front();
			if (rv !== e.value)
				report($sformatf("result %0d read_value %0d, predicted %0d", n_checked, rv,
					e.value));
			if (st !== e.status)
				report($sformatf("result %0d status %0d, predicted %0d", n_checked, st,
					e.status));
			if (cnt !== e.count)
				report($sformatf("result %0d entry_count %0d, predicted %0d", n_checked, cnt,
					e.count));
			n_checked++;
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	req_code_t                req_type;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] item_value;
	logic                     done;
	logic signed [DATA_W-1:0] read_value;
	status_t                  status;
	logic [COUNT_W-1:0]       entry_count;

	list_scoreboard sb;
	int unsigned cycle_count = 0;

	indexed_list_store_top #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.position   (position),
		.item_value (item_value),
		.done       (done),
		.read_value (read_value),
		.status     (status),
		.entry_count(entry_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Results cannot be held off, so every done pulse is one result.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(read_value, status, entry_count);
	end

	task automatic send_request(input req_code_t kind, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] v);
		@(negedge clk);
		start = 1'b1;
		req_type = kind;
		position = pos;
		item_value = v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(kind, pos, v);
	endtask

	// Idle cycles; the payload carries junk while start is low.
	task automatic hold_off(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
			req_type = req_code_t'($urandom);
			position = POS_W'($urandom);
			item_value = $urandom;
		end
	endtask

	task automatic wait_all_results();
		hold_off(1);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [POS_W-1:0] pick_position(input int unsigned limit);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return POS_W'($urandom);
		if (r < 30)
			return POS_W'(limit + 1);
		return POS_W'($urandom_range(0, limit));
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return VALUE_MAX;
			1: return VALUE_MIN;
			2: return OUT_OF_RANGE_VALUE;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Weights are percentages; what is left over goes to unused request codes,
	// which do not count toward the number of items.
	task automatic run_phase(input int unsigned n_items, input int unsigned w_read,
			input int unsigned w_ins, input int unsigned w_del, input bit allow_gaps);
		int unsigned done_items;
		int unsigned burst_left;
		int unsigned r;
		int unsigned last_pos;
		req_code_t kind;
		logic [POS_W-1:0] pos;
		done_items = 0;
		burst_left = $urandom_range(1, 24);
		while (done_items < n_items) begin
			r = $urandom_range(0, 99);
			last_pos = (sb.count == 0) ? 0 : sb.count - 1;
			if (r < w_read) begin
				kind = REQ_READ;
				pos = pick_position(last_pos);
			end else if (r < w_read + w_ins) begin
				case ($urandom_range(0, 2))
					0: kind = REQ_INSERT_HEAD;
					1: kind = REQ_INSERT_TAIL;
					default: kind = REQ_INSERT_AT;
				endcase
				pos = pick_position(sb.count);
			end else if (r < w_read + w_ins + w_del) begin
				kind = REQ_DELETE;
				pos = pick_position(last_pos);
			end else begin
				case ($urandom_range(0, 2))
					0: kind = REQ_UNUSED_A;
					1: kind = REQ_UNUSED_B;
					default: kind = REQ_UNUSED_C;
				endcase
				pos = POS_W'($urandom);
			end
			send_request(kind, pos, pick_value());
			if (kind <= REQ_DELETE)
				done_items++;
			burst_left--;
			if (burst_left == 0) begin
				if (allow_gaps && $urandom_range(0, 9) < 7)
					hold_off($urandom_range(1, 8));
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_READ;
		position = '0;
		item_value = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty store, extreme values, boundaries and unused codes.
		send_request(REQ_READ, 8'd0, 32'sd0);
		send_request(REQ_DELETE, 8'd0, 32'sd0);
		send_request(REQ_INSERT_AT, 8'd1, 32'sd5);
		send_request(REQ_INSERT_AT, 8'd0, VALUE_MAX);
		send_request(REQ_INSERT_HEAD, 8'd0, VALUE_MIN);
		send_request(REQ_INSERT_TAIL, 8'd255, OUT_OF_RANGE_VALUE);
		send_request(REQ_INSERT_TAIL, 8'd0, 32'sd0);
		send_request(REQ_INSERT_AT, 8'd2, 32'sh5555_aaaa);
		hold_off(2);
		send_request(REQ_INSERT_AT, 8'd5, 32'shaaaa_5555);
		send_request(REQ_READ, 8'd0, VALUE_MAX);
		send_request(REQ_READ, 8'd5, 32'sd0);
		send_request(REQ_READ, 8'd6, 32'sd0);
		send_request(REQ_READ, 8'd255, 32'sd0);
		send_request(REQ_INSERT_AT, 8'd255, VALUE_MAX);
		send_request(REQ_DELETE, 8'd255, 32'sd0);
		send_request(REQ_UNUSED_A, 8'd0, 32'sd0);
		send_request(REQ_UNUSED_B, 8'd255, VALUE_MIN);
		send_request(REQ_UNUSED_C, 8'd3, OUT_OF_RANGE_VALUE);
		send_request(REQ_DELETE, 8'd2, 32'sd0);
		send_request(REQ_DELETE, 8'd4, 32'sd0);
		send_request(REQ_DELETE, 8'd0, 32'sd0);
		send_request(REQ_READ, 8'd2, 32'sd0);
		send_request(REQ_READ, 8'd3, 32'sd0);
		wait_all_results();

		run_phase(300, 30, 35, 30, 1'b1);
		wait_all_results();
		// Grow until the store is full, then keep pushing against the limit.
		run_phase(250, 15, 75, 8, 1'b1);
		wait_all_results();
		run_phase(120, 30, 50, 15, 1'b1);
		wait_all_results();
		run_phase(250, 15, 15, 65, 1'b1);
		wait_all_results();
		run_phase(240, 30, 33, 32, 1'b0);
		run_phase(240, 30, 33, 32, 1'b1);
		wait_all_results();
		hold_off(10);

		$display("Checked %0d results: %0d reads, %0d inserts, %0d deletes, %0d unused codes.",
			sb.n_checked, sb.n_read, sb.n_insert, sb.n_delete, sb.n_unknown);
		$display("Saw %0d full refusals, %0d range rejections, peak entry count %0d.",
			sb.n_full, sb.n_range, sb.peak_count);
		if (sb.error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
